// ===== rtl/core/uart_datagram_crc8_framer_macros.svh =====
// Assertion macros for the UART datagram framer.
// Used by the top level; needs a clock and an active-low reset name per use.
`ifndef UART_DATAGRAM_CRC8_FRAMER_MACROS_SVH
`define UART_DATAGRAM_CRC8_FRAMER_MACROS_SVH

`ifndef SYNTH
`define UCF_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
        else $error("ucf: invariant violated");
`define UCF_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ucf: implication violated");
`else
`define UCF_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr)
`define UCF_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== rtl/core/ucf_pkg.sv =====
// Shared types, constants and the CRC-8 helper of the UART datagram framer.
// No dependencies.
`timescale 1ns / 1ps

package ucf_pkg;

    localparam int WRITE_CRC_INDEX = 7;
    localparam int READ_CRC_INDEX  = 3;
    localparam int ECHO_BYTES      = 4;
    localparam int REPLY_LEN       = 8;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam int JOB_FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W     = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W     = $clog2(JOB_FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 1'b1;

    localparam logic [7:0] SYNC_BYTE_RESET     = 8'h05;
    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h00;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_RX    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        JOB_WRITE = 2'd0,
        JOB_READ  = 2'd1,
        JOB_REPLY = 2'd2
    } job_kind_t;

    // One queued job: a request to serialize or a checked reply to report.
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  addr;
        logic [31:0] data;
        logic        err;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // CRC-8, polynomial 0x07, byte fed least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (c[7] ^ b[k])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ucf_in_if.sv =====
// Input channel of the framer: requests and received line bytes.
// No dependencies.
`timescale 1ns / 1ps

interface ucf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  reg_addr;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;

    modport source (output valid, action, reg_addr, write_value, rx_byte, input ready);
    modport sink   (input valid, action, reg_addr, write_value, rx_byte, output ready);
endinterface

// ===== rtl/core/ucf_out_if.sv =====
// Output channel of the framer: transmit bytes and checked replies.
// No dependencies.
`timescale 1ns / 1ps

interface ucf_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic        reply_valid;
    logic [31:0] reply_data;
    logic        crc_error;

    modport source (output valid, tx_valid, tx_byte, last_byte, reply_valid, reply_data,
                    crc_error, input ready);
    modport sink   (input valid, tx_valid, tx_byte, last_byte, reply_valid, reply_data,
                    crc_error, output ready);
endinterface

// ===== rtl/core/ucf_front.sv =====
// Front end: accepts words, runs the reply receiver and queues jobs.
// Depends on ucf_pkg and ucf_in_if.
`timescale 1ns / 1ps

module ucf_front (
    input  logic                clk,
    input  logic                rst_n,
    ucf_in_if.sink              item,
    input  ucf_pkg::fifo_stat_t fifo_stat,
    output logic                push,
    output ucf_pkg::job_t       push_job
);

    logic [2:0]  echo_skip_reg,   echo_skip_next;
    logic [3:0]  reply_count_reg, reply_count_next;
    logic [7:0]  reply_crc_reg,   reply_crc_next;
    logic [31:0] reply_shift_reg, reply_shift_next;
    logic        accept;

    assign item.ready = !fifo_stat.full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        echo_skip_next   = echo_skip_reg;
        reply_count_next = reply_count_reg;
        reply_crc_next   = reply_crc_reg;
        reply_shift_next = reply_shift_reg;
        push             = 1'b0;
        push_job.kind    = ucf_pkg::JOB_WRITE;
        push_job.addr    = item.reg_addr;
        push_job.data    = item.write_value;
        push_job.err     = 1'b0;
        if (accept)
        begin
            unique case (item.action)
                ucf_pkg::ACT_WRITE:
                begin
                    push = 1'b1;
                end
                ucf_pkg::ACT_READ:
                begin
                    push             = 1'b1;
                    push_job.kind    = ucf_pkg::JOB_READ;
                    echo_skip_next   = 3'(ucf_pkg::ECHO_BYTES);
                    reply_count_next = 4'd0;
                    reply_crc_next   = 8'h00;
                    reply_shift_next = 32'h0;
                end
                ucf_pkg::ACT_RX:
                begin
                    // The own echo is dropped before reply bytes are collected.
                    if (echo_skip_reg != 3'd0)
                    begin
                        echo_skip_next = echo_skip_reg - 3'd1;
                    end
                    else if (reply_count_reg < 4'(ucf_pkg::REPLY_LEN - 1))
                    begin
                        reply_crc_next   = ucf_pkg::crc8_byte(reply_crc_reg, item.rx_byte);
                        reply_shift_next = {reply_shift_reg[23:0], item.rx_byte};
                        reply_count_next = reply_count_reg + 4'd1;
                    end
                    else if (reply_count_reg == 4'(ucf_pkg::REPLY_LEN - 1))
                    begin
                        reply_count_next = 4'(ucf_pkg::REPLY_LEN);
                        push             = 1'b1;
                        push_job.kind    = ucf_pkg::JOB_REPLY;
                        push_job.data    = reply_shift_reg;
                        push_job.err     = (reply_crc_reg != item.rx_byte);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_skip_reg   <= 3'd0;
            reply_count_reg <= 4'(ucf_pkg::REPLY_LEN);
            reply_crc_reg   <= 8'h00;
            reply_shift_reg <= 32'h0;
        end
        else
        begin
            echo_skip_reg   <= echo_skip_next;
            reply_count_reg <= reply_count_next;
            reply_crc_reg   <= reply_crc_next;
            reply_shift_reg <= reply_shift_next;
        end
    end

endmodule

// ===== rtl/core/ucf_job_fifo.sv =====
// Short job queue between the front end and the serializer.
// Depends on ucf_pkg.
`timescale 1ns / 1ps

module ucf_job_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ucf_pkg::job_t       push_job,
    input  logic                pop,
    output ucf_pkg::job_t       head,
    output ucf_pkg::fifo_stat_t stat
);

    localparam logic [ucf_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        ucf_pkg::FIFO_PTR_W'(ucf_pkg::JOB_FIFO_DEPTH - 1);
    localparam logic [ucf_pkg::FIFO_CNT_W-1:0] CNT_ONE = ucf_pkg::FIFO_CNT_W'(1);

    ucf_pkg::job_t                   entry_reg [ucf_pkg::JOB_FIFO_DEPTH];
    logic [ucf_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [ucf_pkg::FIFO_CNT_W-1:0]  count_reg;
    logic                            do_push, do_pop;

    assign stat.full  = (count_reg == ucf_pkg::FIFO_CNT_W'(ucf_pkg::JOB_FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_ONE;
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_ONE;
        end
    end

endmodule

// ===== rtl/core/ucf_back.sv =====
// Back end: serializes request datagrams with their CRC and reports replies.
// Depends on ucf_pkg and ucf_out_if.
`timescale 1ns / 1ps

module ucf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ucf_pkg::job_t       head,
    input  ucf_pkg::fifo_stat_t fifo_stat,
    input  logic [7:0]          sync_byte,
    input  logic [7:0]          slave_address,
    output logic                pop,
    ucf_out_if.source           result
);

    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;
    logic        reply_valid_reg, reply_valid_next;
    logic [31:0] reply_data_reg, reply_data_next;
    logic        crc_error_reg, crc_error_next;
    logic        load;
    logic        is_crc;
    logic [2:0]  crc_idx;
    logic [7:0]  sel_byte;
    logic [7:0]  line_byte;

    // A new word enters the output register whenever it is empty or being taken.
    assign load = !fifo_stat.empty && (!valid_reg || result.ready);

    assign crc_idx = (head.kind == ucf_pkg::JOB_WRITE) ? 3'(ucf_pkg::WRITE_CRC_INDEX)
                                                       : 3'(ucf_pkg::READ_CRC_INDEX);
    assign is_crc  = (idx_reg == crc_idx);

    always_comb
    begin
        case (idx_reg)
            3'd0:    sel_byte = sync_byte;
            3'd1:    sel_byte = slave_address;
            3'd2:    sel_byte = head.addr;
            3'd3:    sel_byte = head.data[31:24];
            3'd4:    sel_byte = head.data[23:16];
            3'd5:    sel_byte = head.data[15:8];
            3'd6:    sel_byte = head.data[7:0];
            default: sel_byte = 8'h00;
        endcase
    end

    assign line_byte = is_crc ? crc_reg : sel_byte;

    always_comb
    begin
        idx_next         = idx_reg;
        crc_next         = crc_reg;
        pop              = 1'b0;
        valid_next       = result.ready ? 1'b0 : valid_reg;
        tx_valid_next    = tx_valid_reg;
        tx_byte_next     = tx_byte_reg;
        last_next        = last_reg;
        reply_valid_next = reply_valid_reg;
        reply_data_next  = reply_data_reg;
        crc_error_next   = crc_error_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (head.kind == ucf_pkg::JOB_REPLY)
            begin
                pop              = 1'b1;
                tx_valid_next    = 1'b0;
                tx_byte_next     = 8'h00;
                last_next        = 1'b0;
                reply_valid_next = 1'b1;
                reply_data_next  = head.data;
                crc_error_next   = head.err;
            end
            else
            begin
                pop              = is_crc;
                idx_next         = is_crc ? 3'd0 : idx_reg + 3'd1;
                crc_next         = is_crc ? 8'h00 : ucf_pkg::crc8_byte(crc_reg, line_byte);
                tx_valid_next    = 1'b1;
                tx_byte_next     = line_byte;
                last_next        = is_crc;
                reply_valid_next = 1'b0;
                reply_data_next  = 32'h0;
                crc_error_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            crc_reg   <= 8'h00;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg    <= tx_valid_next;
        tx_byte_reg     <= tx_byte_next;
        last_reg        <= last_next;
        reply_valid_reg <= reply_valid_next;
        reply_data_reg  <= reply_data_next;
        crc_error_reg   <= crc_error_next;
    end

    assign result.valid       = valid_reg;
    assign result.tx_valid    = tx_valid_reg;
    assign result.tx_byte     = tx_byte_reg;
    assign result.last_byte   = last_reg;
    assign result.reply_valid = reply_valid_reg;
    assign result.reply_data  = reply_data_reg;
    assign result.crc_error   = crc_error_reg;

endmodule

// ===== rtl/core/uart_datagram_crc8_framer.sv =====
// Top level of the UART datagram framer: config registers, front end, job queue, serializer.
// A request or reply first passes the job queue, then the serializer's output register,
// which gives one output word per cycle while the queue holds jobs and the output is taken;
// a write is 8 bytes, a read 4, a reply 1 word; received bytes with no result give none.
// Reset (async, active low) idles the receiver, empties the queue and restores config.
`timescale 1ns / 1ps
`include "uart_datagram_crc8_framer_macros.svh"

module uart_datagram_crc8_framer (
    input  logic                               clk,
    input  logic                               rst_n,
    ucf_in_if.sink                             item,
    ucf_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [ucf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_wdata
);

    logic [7:0]          sync_byte_reg;
    logic [7:0]          slave_address_reg;
    logic                push;
    logic                pop;
    ucf_pkg::job_t       push_job;
    ucf_pkg::job_t       head;
    ucf_pkg::fifo_stat_t fifo_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg     <= ucf_pkg::SYNC_BYTE_RESET;
            slave_address_reg <= ucf_pkg::SLAVE_ADDRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ucf_pkg::CFG_SYNC_BYTE:     sync_byte_reg     <= cfg_wdata;
                ucf_pkg::CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_wdata;
            endcase
        end
    end

    ucf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_job  (push_job)
    );

    ucf_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    ucf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .fifo_stat     (fifo_stat),
        .sync_byte     (sync_byte_reg),
        .slave_address (slave_address_reg),
        .pop           (pop),
        .result        (result)
    );

    `UCF_ASSERT_ALWAYS(a_no_push_when_full, clk, rst_n, !(push && fifo_stat.full))
    `UCF_ASSERT_ALWAYS(a_no_pop_when_empty, clk, rst_n, !(pop && fifo_stat.empty))
    `UCF_ASSERT_IMPLY(a_one_kind, clk, rst_n, result.valid, result.tx_valid != result.reply_valid)
    `UCF_ASSERT_IMPLY(a_last_is_tx, clk, rst_n, result.valid && result.last_byte, result.tx_valid)

endmodule
